FILE: hdl/ecc_pkg.sv
// shared constants for the elevator car controller
`default_nettype none

package ecc_pkg;

	localparam int unsigned NUM_FLOORS       = 8;
	localparam int unsigned QUEUE_DEPTH_DEF  = 8;

	localparam int unsigned OP_W        = 3;
	localparam int unsigned FLOOR_W     = 3;
	localparam int unsigned FLOOR_CMP_W = FLOOR_W + 1;
	localparam int unsigned TICKS_W     = 10;
	localparam int unsigned PITCH_W     = 8;
	localparam int unsigned WINDOW_W    = 8;
	localparam int unsigned STEPS_W     = 11;
	localparam int unsigned LAMPS_W     = 8;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 10;

	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_HALL_CALL  = 3'd1;
	localparam logic [OP_W-1:0] OP_CABIN      = 3'd2;
	localparam logic [OP_W-1:0] OP_DOOR_OPEN  = 3'd3;
	localparam logic [OP_W-1:0] OP_DOOR_CLOSE = 3'd4;
	localparam logic [OP_W-1:0] OP_STOP       = 3'd5;
	localparam logic [OP_W-1:0] OP_VENT       = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_OPEN_TICKS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_EXTENDED_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_PITCH         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_WINDOW       = 2'd3;

	localparam logic [TICKS_W-1:0]  RST_DOOR_OPEN_TICKS     = 10'd375;
	localparam logic [TICKS_W-1:0]  RST_DOOR_EXTENDED_TICKS = 10'd750;
	localparam logic [PITCH_W-1:0]  RST_FLOOR_PITCH         = 8'd75;
	localparam logic [WINDOW_W-1:0] RST_ARRIVE_WINDOW       = 8'd6;
	localparam logic [FLOOR_W-1:0]  RST_FLOOR               = 3'd2;
	localparam logic [STEPS_W-1:0]  RST_CAR_STEPS           = 11'd150;

endpackage

`default_nettype wire

FILE: hdl/elevator_car_controller.sv
// Elevator car controller: single car, request queue, doors, lamps, ventilation.
// Each accepted event (tick or request) yields exactly one status transfer. The event is
// held in the input register after its acceptance, and from there it moves through the
// state update into the result register, where the result is offered. A result that
// waits on out_ready holds the input register, and a new event is then taken in the
// cycle the result leaves. One event is taken every cycle while results drain, since all
// car, door and queue state is updated combinationally by one small multiply (goal floor
// times pitch) followed by a step, an absolute distance and a compare.
// The request queue is a shift-register FIFO with a parallel duplicate compare; no clearing
// pass after reset. Configuration writes are taken at any time but must only be issued
// while idle.
`default_nettype none

module elevator_car_controller
	import ecc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [FLOOR_W-1:0]    floor,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [FLOOR_W-1:0]         current_floor,
	output logic [FLOOR_W-1:0]         target_floor,
	output logic                       moving,
	output logic                       doors_open,
	output logic [STEPS_W-1:0]         car_position,
	output logic [LAMPS_W-1:0]         lamps,
	output logic                       ventilation_on,
	output logic [CNT_W-1:0]           queue_count,
	output logic                       arrived
);

	// configuration
	logic [TICKS_W-1:0]  door_open_ticks_q;
	logic [TICKS_W-1:0]  door_ext_ticks_q;
	logic [PITCH_W-1:0]  pitch_q;
	logic [WINDOW_W-1:0] window_q;

	// input stage
	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [FLOOR_W-1:0]  fl_s1;

	// car state
	logic [FLOOR_W-1:0]  queue_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [FLOOR_W-1:0]  car_q;
	logic [FLOOR_W-1:0]  goal_q;
	logic [STEPS_W-1:0]  steps_q;
	logic                trav_q;
	logic                open_q;
	logic [TICKS_W-1:0]  dt_q;
	logic                ext_q;
	logic                fan_q;
	logic [LAMPS_W-1:0]  lamps_q;

	// result register
	logic                out_valid_q;
	logic [FLOOR_W-1:0]  res_car_q;
	logic [FLOOR_W-1:0]  res_goal_q;
	logic                res_trav_q;
	logic                res_open_q;
	logic [STEPS_W-1:0]  res_steps_q;
	logic [LAMPS_W-1:0]  res_lamps_q;
	logic                res_fan_q;
	logic [CNT_W-1:0]    res_count_q;
	logic                res_arrived_q;

	logic                advance;

	// next state
	logic [CNT_W-1:0]    count_d;
	logic [FLOOR_W-1:0]  car_d;
	logic [FLOOR_W-1:0]  goal_d;
	logic [STEPS_W-1:0]  steps_d;
	logic                trav_d;
	logic                open_d;
	logic [TICKS_W-1:0]  dt_d;
	logic                ext_d;
	logic                fan_d;
	logic [LAMPS_W-1:0]  lamps_d;
	logic                arrive_d;
	logic                push;
	logic                pop;

	// tick datapath
	logic [TICKS_W-1:0]  dt_inc;
	logic [TICKS_W-1:0]  limit;
	logic                timeout;
	logic                open_tick;
	logic                pop_ok;
	logic [FLOOR_W-1:0]  goal_tick;
	logic                trav_tick;
	logic [STEPS_W-1:0]  target;
	logic [STEPS_W-1:0]  step_pos;
	logic [STEPS_W-1:0]  gap_steps;
	logic                near;

	// request datapath
	logic                fl_ok;
	logic                here_idle;
	logic                dup;
	logic                room;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_open_ticks_q <= RST_DOOR_OPEN_TICKS;
			door_ext_ticks_q  <= RST_DOOR_EXTENDED_TICKS;
			pitch_q           <= RST_FLOOR_PITCH;
			window_q          <= RST_ARRIVE_WINDOW;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DOOR_OPEN_TICKS:     door_open_ticks_q <= cfg_data;
				CFG_DOOR_EXTENDED_TICKS: door_ext_ticks_q  <= cfg_data;
				CFG_FLOOR_PITCH:         pitch_q           <= cfg_data[PITCH_W-1:0];
				CFG_ARRIVE_WINDOW:       window_q          <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			fl_s1 <= floor;
		end
	end

	// door timer and car motion
	assign dt_inc    = dt_q + TICKS_W'(1);
	assign limit     = ext_q ? door_ext_ticks_q : door_open_ticks_q;
	assign timeout   = open_q && (dt_inc >= limit);
	assign open_tick = open_q && !timeout;
	assign pop_ok    = (count_q != '0) && !trav_q && !open_tick;
	assign goal_tick = pop_ok ? queue_q[0] : goal_q;
	assign trav_tick = trav_q || pop_ok;
	assign target    = STEPS_W'(goal_tick) * STEPS_W'(pitch_q);

	always_comb begin
		if (target > steps_q) begin
			step_pos = (steps_q == '1) ? steps_q : steps_q + STEPS_W'(1);
		end else begin
			step_pos = (steps_q == '0) ? steps_q : steps_q - STEPS_W'(1);
		end
	end

	assign gap_steps = (step_pos > target) ? step_pos - target : target - step_pos;
	assign near      = gap_steps < STEPS_W'(window_q);

	// request handling
	assign fl_ok     = FLOOR_CMP_W'(fl_s1) < FLOOR_CMP_W'(NUM_FLOORS);
	assign here_idle = (fl_s1 == car_q) && !trav_q;
	assign room      = count_q < CNT_W'(QUEUE_DEPTH);

	always_comb begin
		dup = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if ((CNT_W'(i) < count_q) && (queue_q[i] == fl_s1)) begin
				dup = 1'b1;
			end
		end
	end

	always_comb begin
		count_d  = count_q;
		car_d    = car_q;
		goal_d   = goal_q;
		steps_d  = steps_q;
		trav_d   = trav_q;
		open_d   = open_q;
		dt_d     = dt_q;
		ext_d    = ext_q;
		fan_d    = fan_q;
		lamps_d  = lamps_q;
		arrive_d = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		unique case (op_s1)
			OP_TICK: begin
				if (timeout) begin
					open_d = 1'b0;
					dt_d   = '0;
					ext_d  = 1'b0;
				end else if (open_q) begin
					dt_d = dt_inc;
				end
				if (pop_ok) begin
					goal_d  = queue_q[0];
					pop     = 1'b1;
					count_d = count_q - CNT_W'(1);
					trav_d  = 1'b1;
				end
				if (trav_tick && !open_tick) begin
					steps_d = step_pos;
					if (near) begin
						steps_d          = target;
						car_d            = goal_tick;
						trav_d           = 1'b0;
						open_d           = 1'b1;
						dt_d             = '0;
						fan_d            = 1'b0;
						lamps_d[goal_tick] = 1'b0;
						arrive_d         = 1'b1;
					end
				end
			end
			OP_HALL_CALL: begin
				if (fl_ok) begin
					if (fl_s1 != car_q) begin
						if (!dup && room) begin
							push    = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end else if (!open_q) begin
						open_d = 1'b1;
						dt_d   = '0;
					end
				end
			end
			OP_CABIN: begin
				if (fl_ok) begin
					if (here_idle) begin
						if (!open_q) begin
							open_d = 1'b1;
							dt_d   = '0;
						end
					end else if (!dup && room) begin
						push    = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
					lamps_d[fl_s1] = 1'b1;
				end
			end
			OP_DOOR_OPEN: begin
				if (open_q) begin
					ext_d = 1'b1;
				end
			end
			OP_DOOR_CLOSE: begin
				if (open_q) begin
					open_d = 1'b0;
					dt_d   = '0;
				end
			end
			OP_STOP: begin
				count_d = '0;
				trav_d  = 1'b0;
				fan_d   = 1'b0;
				lamps_d = '0;
			end
			OP_VENT: begin
				fan_d = !fan_q;
			end
			default: ;
		endcase
	end

	// request fifo, shifts toward entry zero on pop
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (pop) begin
					if (i < QUEUE_DEPTH - 1) begin
						queue_q[i] <= queue_q[i+1];
					end
				end else if (push && (CNT_W'(i) == count_q)) begin
					queue_q[i] <= fl_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			car_q   <= RST_FLOOR;
			goal_q  <= RST_FLOOR;
			steps_q <= RST_CAR_STEPS;
			trav_q  <= 1'b0;
			open_q  <= 1'b0;
			dt_q    <= '0;
			ext_q   <= 1'b0;
			fan_q   <= 1'b0;
			lamps_q <= '0;
		end else if (advance) begin
			count_q <= count_d;
			car_q   <= car_d;
			goal_q  <= goal_d;
			steps_q <= steps_d;
			trav_q  <= trav_d;
			open_q  <= open_d;
			dt_q    <= dt_d;
			ext_q   <= ext_d;
			fan_q   <= fan_d;
			lamps_q <= lamps_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_car_q     <= car_d;
			res_goal_q    <= goal_d;
			res_trav_q    <= trav_d;
			res_open_q    <= open_d;
			res_steps_q   <= steps_d;
			res_lamps_q   <= lamps_d;
			res_fan_q     <= fan_d;
			res_count_q   <= count_d;
			res_arrived_q <= arrive_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign current_floor  = res_car_q;
	assign target_floor   = res_goal_q;
	assign moving         = res_trav_q;
	assign doors_open     = res_open_q;
	assign car_position   = res_steps_q;
	assign lamps          = res_lamps_q;
	assign ventilation_on = res_fan_q;
	assign queue_count    = res_count_q;
	assign arrived        = res_arrived_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("request count beyond queue depth");

	a_arrive_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_arrived_q |-> res_open_q && !res_trav_q && !res_fan_q)
		else $error("arrival without open doors and halted car");

	a_arrive_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_arrived_q |-> !res_lamps_q[res_car_q] && (res_car_q == res_goal_q))
		else $error("arrival left lamp lit or floor mismatch");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("pending result dropped");
`endif

endmodule

`default_nettype wire
